FILE: src/mtkd_pkg.sv
package mtkd_pkg;

    localparam int unsigned MT_N      = 624;
    localparam int unsigned MT_M      = 397;
    localparam int unsigned IDX_W     = $clog2(MT_N);
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [WORD_W-1:0] MT_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] MT_UPPER  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(MT_N - 1);
    localparam logic [IDX_W-1:0] IDX_FAR_OFS  = IDX_W'(MT_M);
    localparam logic [IDX_W-1:0] IDX_FAR_WRAP = IDX_W'(MT_N - MT_M);

    localparam logic [WORD_W-1:0] SEED_RST       = '0;
    localparam logic [BYTE_W-1:0] KEY_START_RST  = 8'hC5;
    localparam logic [BYTE_W-1:0] STEP_START_RST = 8'h83;
    localparam logic [BYTE_W-1:0] STEP_DELTA_RST = 8'h53;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED       = 4'd0,
        REG_KEY_START  = 4'd1,
        REG_STEP_START = 4'd2,
        REG_STEP_DELTA = 4'd3
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic seed_init;
        logic seed_mul;
        logic seed_add;
        logic rd_far;
        logic calc;
        logic out_load;
    } mtkd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seeded;
        logic seed_last;
        logic out_free;
    } mtkd_status_t;

    // One step of the generator recurrence, done lazily for a single entry.
    function automatic logic [WORD_W-1:0] mt_twist(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & MT_UPPER) | (nxt & MT_LOWER);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ MT_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: src/mtkd_ram.sv
module mtkd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/mtkd_ctrl.sv
module mtkd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  mtkd_pkg::mtkd_status_t status,
    output mtkd_pkg::mtkd_cmd_t    cmd
);

    import mtkd_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SEED_INIT = 8'b0000_0010,
        ST_SEED_MUL  = 8'b0000_0100,
        ST_SEED_ADD  = 8'b0000_1000,
        ST_RD_NEXT   = 8'b0001_0000,
        ST_RD_FAR    = 8'b0010_0000,
        ST_CALC      = 8'b0100_0000,
        ST_OUT       = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    // The read of the following entry is issued in this cycle.
                    if (s_tuser || !status.seeded) begin
                        state_next = ST_SEED_INIT;
                    end else begin
                        state_next = ST_RD_FAR;
                    end
                end
            end
            ST_SEED_INIT: begin
                cmd.seed_init = 1'b1;
                state_next    = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                cmd.seed_mul = 1'b1;
                state_next   = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                cmd.seed_add = 1'b1;
                if (status.seed_last) begin
                    state_next = ST_RD_NEXT;
                end else begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_RD_NEXT: begin
                state_next = ST_RD_FAR;
            end
            ST_RD_FAR: begin
                cmd.rd_far = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/mtkd_datapath.sv
module mtkd_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mtkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtkd_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic [mtkd_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [mtkd_pkg::BYTE_W-1:0]     m_tdata,
    input  mtkd_pkg::mtkd_cmd_t              cmd,
    output mtkd_pkg::mtkd_status_t           status
);

    import mtkd_pkg::*;

    // Configuration registers.
    logic [WORD_W-1:0] seed_cfg_reg;
    logic [BYTE_W-1:0] key_start_reg;
    logic [BYTE_W-1:0] step_start_reg;
    logic [BYTE_W-1:0] step_delta_reg;

    // Generator and key state.
    logic              seeded_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] key_reg;
    logic [BYTE_W-1:0] step_reg;

    // Payload registers.
    logic [BYTE_W-1:0] data_reg;
    logic [WORD_W-1:0] p_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] nxt_reg;
    logic [BYTE_W-1:0] res_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]    idx_inc;
    logic [IDX_W-1:0]    idx_far;
    logic [WORD_W-1:0]   p_mix;
    logic [WORD_W-1:0]   seed_prod;
    logic [WORD_W-1:0]   seed_word;
    logic [WORD_W-1:0]   twist_word;
    logic [WORD_W-1:0]   temper_word;
    logic [BYTE_W-1:0]   res;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_far = (idx_reg >= IDX_FAR_WRAP) ? idx_reg - IDX_FAR_WRAP
                                               : idx_reg + IDX_FAR_OFS;

    // Only the low word of the product is kept by the seed recurrence.
    assign p_mix     = p_reg ^ (p_reg >> 30);
    assign seed_prod = SEED_MULT * p_mix;
    assign seed_word = prod_reg + {{(WORD_W-IDX_W){1'b0}}, cnt_reg};

    assign twist_word  = mt_twist(cur_reg, nxt_reg, ram_rdata);
    assign temper_word = mt_temper(twist_word);
    assign res         = data_reg ^ temper_word[BYTE_W-1:0] ^ key_reg;

    always_comb begin
        ram_we    = cmd.seed_init | cmd.seed_add | cmd.calc;
        ram_waddr = idx_reg;
        ram_wdata = twist_word;
        if (cmd.seed_init) begin
            ram_waddr = '0;
            ram_wdata = seed_cfg_reg;
        end else if (cmd.seed_add) begin
            ram_waddr = cnt_reg;
            ram_wdata = seed_word;
        end
        ram_raddr = cmd.rd_far ? idx_far : idx_inc;
    end

    mtkd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MT_N)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_cfg_reg   <= SEED_RST;
            key_start_reg  <= KEY_START_RST;
            step_start_reg <= STEP_START_RST;
            step_delta_reg <= STEP_DELTA_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEED:       seed_cfg_reg   <= cfg_wdata;
                REG_KEY_START:  key_start_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_STEP_START: step_start_reg <= cfg_wdata[BYTE_W-1:0];
                REG_STEP_DELTA: step_delta_reg <= cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg    <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            key_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.seed_init) begin
                seeded_reg <= 1'b1;
                idx_reg    <= '0;
                cnt_reg    <= IDX_W'(1);
                key_reg    <= key_start_reg;
                step_reg   <= step_start_reg;
            end
            if (cmd.seed_add) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.calc) begin
                idx_reg  <= idx_inc;
                key_reg  <= key_reg + step_reg;
                step_reg <= step_reg + step_delta_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            data_reg <= s_tdata;
        end
        if (cmd.seed_init) begin
            p_reg   <= seed_cfg_reg;
            cur_reg <= seed_cfg_reg;
        end
        if (cmd.seed_mul) begin
            prod_reg <= seed_prod;
        end
        if (cmd.seed_add) begin
            p_reg <= seed_word;
        end
        if (cmd.rd_far) begin
            nxt_reg <= ram_rdata;
        end
        if (cmd.calc) begin
            // The next entry read earlier is still untwisted: it becomes
            // the current word of the following byte.
            cur_reg <= nxt_reg;
            res_reg <= res;
        end
        if (cmd.out_load) begin
            out_data_reg <= cmd.calc ? res : res_reg;
        end
    end

    assign status.seeded    = seeded_reg;
    assign status.seed_last = (cnt_reg == IDX_LAST);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: src/mt_keystream_byte_decrypt.sv
// Keystream byte decryptor built on a standard MT19937 generator.
//
// Input stream (s_): one ciphertext byte per beat on s_tdata; s_tuser marks
// the first byte of a buffer. A start beat, or any beat that arrives before
// the generator has ever been seeded, reseeds the generator from the seed
// register and reloads the additive key and step from their registers.
// Output stream (m_): one plaintext byte per input beat, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 seed,
// 1 key_start, 2 step_start, 3 step_delta); other indexes are ignored.
// Write registers only while the block is idle; seed, key_start and
// step_start apply at the next start, step_delta from the next byte on.
// A byte is accepted while the following table entry is read, then the far
// entry is read, then the word is twisted, tempered and output; the pace is
// set by the single read port of the 624-word table, and no new byte is
// taken until the last is loaded into the output register. A reseeding beat
// first fills the table with the seed recurrence, one entry at a time,
// through one registered 32x32 multiplier.
// Reset clears the control state and restores register defaults; the table
// itself is not cleared. If the receiver stalls, the result is held in the
// output register and one further beat is still taken in and processed.
module mt_keystream_byte_decrypt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mtkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtkd_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mtkd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] start_req
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mtkd_pkg::BYTE_W-1:0]     m_tdata    // [7:0] plain_byte
);

    import mtkd_pkg::*;

    mtkd_cmd_t    cmd;
    mtkd_status_t status;

    // The controller sequences seeding, table reads and output handoff.
    mtkd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the table, the key state and the output register.
    mtkd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTHESIS
    // Only one table operation is commanded in any cycle.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.seed_init, cmd.seed_mul, cmd.seed_add, cmd.rd_far, cmd.calc}))
        else $error("conflicting table commands");

    // A start beat, or the first beat ever, must begin a reseed.
    a_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser || !status.seeded)) |=> cmd.seed_init)
        else $error("reseed not started");

    // An ordinary beat reads the far entry next cycle and twists the one after.
    a_byte_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && status.seeded)
            |=> cmd.rd_far ##1 cmd.calc)
        else $error("byte sequence out of order");

    // A result appears only after the controller loaded the output register.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output valid without a load");
`endif

endmodule

FILE: tb/mtkd_checker.sv
module mtkd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mtkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtkd_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mtkd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] start_req
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mtkd_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] plain_byte
    output int unsigned                     fail_count,
    output int unsigned                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtkd_pkg::*;

    localparam int unsigned       TABLE_LEN = 624;
    localparam int unsigned       FAR_OFS   = 397;
    localparam logic [31:0]       TWIST_XOR = 32'h9908_B0DF;
    localparam logic [31:0]       TEMPER_B  = 32'h9D2C_5680;
    localparam logic [31:0]       TEMPER_C  = 32'hEFC6_0000;

    // Register copies; all but step_delta are loaded at each buffer start.
    logic [31:0] seed_reg;
    logic [7:0]  key_start_reg;
    logic [7:0]  step_start_reg;
    logic [7:0]  step_delta_reg;

    // Generator and additive key state.
    logic [31:0] gen_words [TABLE_LEN];
    int unsigned gen_pos;
    bit          gen_ready;
    logic [7:0]  add_key;
    logic [7:0]  add_step;

    logic [7:0]  plain_q [$];
    int unsigned mismatches;

    always @(posedge aclk) begin : track
        logic [31:0] p;
        logic [31:0] y;
        logic [31:0] v;
        logic [7:0]  want;
        if (!aresetn) begin
            seed_reg       = SEED_RST;
            key_start_reg  = KEY_START_RST;
            step_start_reg = STEP_START_RST;
            step_delta_reg = STEP_DELTA_RST;
            gen_pos        = 0;
            gen_ready      = 1'b0;
            add_key        = '0;
            add_step       = '0;
            mismatches     = 0;
            plain_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                // A start beat, or the very first beat, seeds the generator.
                if (s_tuser || !gen_ready) begin
                    gen_words[0] = seed_reg;
                    for (int i = 1; i < TABLE_LEN; i++) begin
                        p = gen_words[i-1];
                        gen_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
                    end
                    gen_pos   = TABLE_LEN;
                    add_key   = key_start_reg;
                    add_step  = step_start_reg;
                    gen_ready = 1'b1;
                end
                // The whole table is regenerated once every word has been used.
                if (gen_pos >= TABLE_LEN) begin
                    for (int k = 0; k < TABLE_LEN; k++) begin
                        y = (gen_words[k] & 32'h8000_0000) |
                            (gen_words[(k + 1) % TABLE_LEN] & 32'h7FFF_FFFF);
                        v = gen_words[(k + FAR_OFS) % TABLE_LEN] ^ (y >> 1);
                        if (y[0]) begin
                            v = v ^ TWIST_XOR;
                        end
                        gen_words[k] = v;
                    end
                    gen_pos = 0;
                end
                y = gen_words[gen_pos];
                gen_pos++;
                y = y ^ (y >> 11);
                y = y ^ ((y << 7) & TEMPER_B);
                y = y ^ ((y << 15) & TEMPER_C);
                y = y ^ (y >> 18);
                want = s_tdata ^ y[7:0] ^ add_key;
                plain_q.insert(plain_q.size(), want);
                add_key  = add_key + add_step;
                add_step = add_step + step_delta_reg;
            end

            if (m_tvalid && m_tready) begin
                if (plain_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: plain_byte expected none, got %02h", $time, m_tdata);
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        $display("%0t ns: plain_byte expected %02h, got %02h",
                                 $time, want, m_tdata);
                    end
                end
            end

            // Writes land at this edge; only step_delta acts without a start.
            if (cfg_we) begin
                case (cfg_index)
                    REG_SEED:       seed_reg       = cfg_wdata;
                    REG_KEY_START:  key_start_reg  = cfg_wdata[7:0];
                    REG_STEP_START: step_start_reg = cfg_wdata[7:0];
                    REG_STEP_DELTA: step_delta_reg = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending    <= plain_q.size();
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtkd_pkg::*;

    // Longest stretch without any beat on either channel. It leaves a wide
    // margin over a full reseed, with room for stalls on top.
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WORD_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;   // [7:0] data_byte
    logic                   s_tuser   = 1'b0; // [0] start_req
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;          // [7:0] plain_byte

    int unsigned            fail_count;
    int unsigned            pending;
    int unsigned            quiet_cycles = 0;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit                     steady = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    mt_keystream_byte_decrypt u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mtkd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver backs off in roughly 16 percent of the cycles, unless steady is set.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end

    // The watchdog ends a run that has stopped moving beats in either direction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one ciphertext beat, after a random number of idle cycles, and
    // returns at the edge where it is taken. tvalid is left high so that the
    // next beat can follow back to back.
    task automatic send_byte(input logic [7:0] data, input logic start);
        if (!steady) begin
            while ($urandom_range(0, 99) < 16) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // The caller has already dropped tvalid. Waits until the checker holds no
    // outstanding plaintext, which is when the block is idle again: every
    // beat it takes in produces exactly one beat out.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Writes every register, plus one write to an unused index that the block
    // must ignore. The byte-wide registers get junk in their upper bits.
    task automatic configure(input logic [31:0] seed, input logic [31:0] key,
                             input logic [31:0] step, input logic [31:0] delta);
        write_reg(REG_SEED, seed);
        write_reg(REG_KEY_START, key);
        write_reg(REG_STEP_START, step);
        write_reg(REG_STEP_DELTA, delta);
        write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom());
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // A register byte that lands on one of the extremes about half the time.
    function automatic logic [31:0] pick_reg();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom());
        endcase
        return {24'($urandom()), b};
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int unsigned n_items;
        bit          start;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults. The first beat is not flagged as a start, but the
        // generator has never been seeded, so the block must seed it anyway.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // All registers at their maximum. The first beats are not starts, so
        // the buffer in progress keeps its seed, key and step; delta acts at once.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // All registers at zero, with nonzero upper bits on the byte registers
        // that must be dropped. Two starts in a row of short buffers.
        configure(32'h0000_0000, 32'hFFFF_FF00, 32'h0000_0100, 32'h8000_0000);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hF0, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random settings with short buffers. Starts are kept rare since each
        // one costs a full reseed of the generator.
        for (int ph = 0; ph < 3; ph++) begin
            configure(pick_seed(), pick_reg(), pick_reg(), pick_reg());
            n_items = $urandom_range(3, 6);
            for (int i = 0; i < n_items; i++) begin
                if (i == 0) begin
                    start = 1'($urandom_range(0, 1));
                end else begin
                    start = ($urandom_range(0, 11) == 0);
                end
                send_byte(8'($urandom()), start);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        // One long buffer that runs past the end of the generator table, so
        // the whole table is regenerated in place. Part of it runs with no
        // idling on either side, and once the sender holds off until every
        // plaintext beat is out.
        configure(pick_seed(), pick_reg(), pick_reg(), pick_reg());
        for (int i = 0; i < 640; i++) begin
            if (i == 100) begin
                steady = 1'b1;
            end
            if (i == 300) begin
                steady = 1'b0;
            end
            if (i == 450) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_byte(8'($urandom()), i == 0);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // Let anything stray come out before the final check.
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
